@@ hdl/xcr_pkg.sv @@
`timescale 1ns / 1ps

package xcr_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_BLK,
    PH_INV,
    PH_DATA,
    PH_CRC1,
    PH_CRC2
  } phase_t;

  typedef enum logic [2:0] {
    V_NONE,
    V_COMMIT,
    V_DUP,
    V_REJECT,
    V_END
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECV,
    ST_DONE,
    ST_ABORT
  } status_t;

  localparam logic [7:0]  CH_SOH    = 8'h01;
  localparam logic [7:0]  CH_STX    = 8'h02;
  localparam logic [7:0]  CH_EOT    = 8'h04;
  localparam logic [7:0]  CH_ACK    = 8'h06;
  localparam logic [7:0]  CH_NAK    = 8'h15;
  localparam logic [7:0]  CH_CAN    = 8'h18;
  localparam logic [7:0]  BLK_SUM   = 8'hFF;
  localparam logic [10:0] SHORT_LEN = 11'd128;
  localparam logic [10:0] LONG_LEN  = 11'd1024;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [9:0] payload_offset;
    verdict_t   verdict;
    logic       packet_is_long;
    status_t    transfer_status;
  } result_t;

endpackage

@@ hdl/xcr_crc16.sv @@
`timescale 1ns / 1ps

module xcr_crc16 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import xcr_pkg::*;

  logic [15:0] c;

  // msb-first crc-16, one byte per pass
  always_comb begin
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

@@ hdl/xcr_fsm.sv @@
`timescale 1ns / 1ps

module xcr_fsm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       rx_byte,
  output xcr_pkg::result_t res
);
  import xcr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        long_r, long_nxt;
  logic [7:0]  block_r, block_nxt;
  logic [7:0]  expected_r, expected_nxt;
  logic [10:0] count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_high_r, crc_high_nxt;
  logic [1:0]  cancel_r, cancel_nxt;
  status_t     status_r, status_nxt;

  logic [15:0] crc_upd;
  logic [7:0]  blk_sum;
  logic [10:0] count_inc;
  logic [1:0]  cancel_inc;

  xcr_crc16 u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  assign blk_sum    = block_r + rx_byte;
  assign count_inc  = count_r + 11'd1;
  assign cancel_inc = cancel_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      long_r     <= 1'b0;
      block_r    <= 8'd0;
      expected_r <= 8'd1;
      count_r    <= 11'd0;
      crc_r      <= 16'd0;
      crc_high_r <= 8'd0;
      cancel_r   <= 2'd0;
      status_r   <= ST_IDLE;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      long_r     <= long_nxt;
      block_r    <= block_nxt;
      expected_r <= expected_nxt;
      count_r    <= count_nxt;
      crc_r      <= crc_nxt;
      crc_high_r <= crc_high_nxt;
      cancel_r   <= cancel_nxt;
      status_r   <= status_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    long_nxt     = long_r;
    block_nxt    = block_r;
    expected_nxt = expected_r;
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    crc_high_nxt = crc_high_r;
    cancel_nxt   = cancel_r;
    status_nxt   = status_r;

    res                = '0;
    res.verdict        = V_NONE;
    res.transfer_status = ST_IDLE;

    case (phase_r)
      PH_START: begin
        if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
          long_nxt   = (rx_byte == CH_STX);
          status_nxt = ST_RECV;
          phase_nxt  = PH_BLK;
          cancel_nxt = 2'd0;
        end else if (rx_byte == CH_EOT) begin
          res.reply_valid = 1'b1;
          res.reply_byte  = CH_ACK;
          res.verdict     = V_END;
          status_nxt      = ST_DONE;
          cancel_nxt      = 2'd0;
        end else if (rx_byte == CH_CAN) begin
          if (cancel_inc >= 2'd2) begin
            status_nxt = ST_ABORT;
            cancel_nxt = 2'd0;
          end else begin
            status_nxt = ST_IDLE;
            cancel_nxt = cancel_inc;
          end
        end else begin
          status_nxt = ST_IDLE;
          cancel_nxt = 2'd0;
        end
      end
      PH_BLK: begin
        block_nxt = rx_byte;
        phase_nxt = PH_INV;
      end
      PH_INV: begin
        if (blk_sum != BLK_SUM) begin
          res.reply_valid = 1'b1;
          res.reply_byte  = CH_NAK;
          phase_nxt       = PH_START;
        end else begin
          count_nxt = 11'd0;
          crc_nxt   = 16'd0;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        res.payload_valid  = 1'b1;
        res.payload_byte   = rx_byte;
        res.payload_offset = count_r[9:0];
        crc_nxt            = crc_upd;
        count_nxt          = count_inc;
        if (count_inc >= (long_r ? LONG_LEN : SHORT_LEN)) begin
          phase_nxt = PH_CRC1;
        end
      end
      PH_CRC1: begin
        crc_high_nxt = rx_byte;
        phase_nxt    = PH_CRC2;
      end
      PH_CRC2: begin
        res.reply_valid = 1'b1;
        if ({crc_high_r, rx_byte} != crc_r) begin
          res.reply_byte = CH_NAK;
          res.verdict    = V_REJECT;
        end else if (block_r == expected_r) begin
          res.reply_byte = CH_ACK;
          res.verdict    = V_COMMIT;
          expected_nxt   = expected_r + 8'd1;
        end else if (block_r == expected_r - 8'd1) begin
          res.reply_byte = CH_ACK;
          res.verdict    = V_DUP;
        end else begin
          res.reply_byte = CH_NAK;
          res.verdict    = V_REJECT;
        end
        phase_nxt = PH_START;
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase

    res.packet_is_long  = long_nxt;
    res.transfer_status = status_nxt;
  end

endmodule

@@ hdl/xmodem_crc_receiver_top.sv @@
`timescale 1ns / 1ps
// pipeline: an accepted byte goes into the input register and its result then into the
// result register, which drives out_valid
// throughput: one byte per cycle unless out_ready stalls a held result; the receive state
// and the byte-wide crc update advance together as a byte moves from input to result register
// reset: synchronous active-low rst_n; empties both registers, returns the receiver
// to waiting for a start byte with expected block 1 and status idle

module xmodem_crc_receiver_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_reply_valid,
  output logic [7:0] out_reply_byte,
  output logic       out_payload_valid,
  output logic [7:0] out_payload_byte,
  output logic [9:0] out_payload_offset,
  output logic [2:0] out_verdict,
  output logic       out_packet_is_long,
  output logic [1:0] out_transfer_status
);
  import xcr_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  result_t    step_res;
  logic       adv;
  logic       in_acc;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  xcr_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .rx_byte (s1_byte_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_rx_byte;
    end
    if (adv) begin
      out_r <= step_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_reply_valid     = out_r.reply_valid;
  assign out_reply_byte      = out_r.reply_byte;
  assign out_payload_valid   = out_r.payload_valid;
  assign out_payload_byte    = out_r.payload_byte;
  assign out_payload_offset  = out_r.payload_offset;
  assign out_verdict         = out_r.verdict;
  assign out_packet_is_long  = out_r.packet_is_long;
  assign out_transfer_status = out_r.transfer_status;

  a_reply_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.reply_valid |->
      (out_r.reply_byte == CH_ACK || out_r.reply_byte == CH_NAK))
    else $error("reply byte is neither ack nor nak");

  a_payload_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.payload_valid |->
      (!out_r.reply_valid && out_r.verdict == V_NONE && out_r.transfer_status == ST_RECV))
    else $error("payload item carries a reply or verdict");

  a_commit_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.verdict == V_COMMIT || out_r.verdict == V_DUP
      || out_r.verdict == V_END) |-> (out_r.reply_valid && out_r.reply_byte == CH_ACK))
    else $error("accepting verdict without ack");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_byte_r))
    else $error("stalled input stage lost its byte");

endmodule
